@@ rtl/aar_pkg.sv @@
// ----------------------------------------------------------------------------
// aar_pkg
// Shared constants and the arctangent table for the axis-angle rotation block.
// ----------------------------------------------------------------------------
package aar_pkg;

	localparam int TurnUnits    = 92160;
	localparam int HalfTurn     = 46080;
	localparam int QuarterTurn  = 23040;
	localparam logic signed [33:0] OneQ30  = 34'sd1073741824;
	localparam logic signed [33:0] GainQ30 = 34'sd652032874;

	// arctangent of 2^-i in Q30
	function automatic logic signed [33:0] atan_q30(input int i);
		logic signed [33:0] r;
		case (i)
			0:  r = 34'sd843314857;
			1:  r = 34'sd497837829;
			2:  r = 34'sd263043837;
			3:  r = 34'sd133525159;
			4:  r = 34'sd67021687;
			5:  r = 34'sd33543516;
			6:  r = 34'sd16775851;
			7:  r = 34'sd8388437;
			8:  r = 34'sd4194283;
			9:  r = 34'sd2097149;
			default: r = (i < 31) ? (34'sd1 <<< (30 - i)) : 34'sd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/axis_angle_rotation_matrix.sv @@
// ----------------------------------------------------------------------------
// axis_angle_rotation_matrix
// Rotation matrix from an axis and an angle, fully pipelined.
//
// channel   signals                              direction
// request   start, busy, axis_x/y/z, angle_deg   in (busy out)
// result    done, m00..m22, saturated            out
//
// one request per cycle; a result passes through the angle, unrolled CORDIC
// and matrix stages. busy is always low. done is a one-cycle
// strobe; the receiver cannot stall. reset clears only the valid bits.
// ----------------------------------------------------------------------------
module axis_angle_rotation_matrix #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [19:0] angle_deg,
	output logic               done,
	output logic signed [15:0] m00, m01, m02,
	output logic signed [15:0] m10, m11, m12,
	output logic signed [15:0] m20, m21, m22,
	output logic               saturated
);
	import aar_pkg::*;

	localparam int Delay = 4 + ((CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS);

	logic               av, cv, mv, ng;
	logic signed [33:0] z, c, s;
	logic signed [15:0] ax_d [Delay+1][3];
	logic signed [15:0] m [9];

	assign busy = 1'b0;

	// axis delay line to meet cos and sin
	assign ax_d[0][0] = axis_x;
	assign ax_d[0][1] = axis_y;
	assign ax_d[0][2] = axis_z;
	for (genvar i = 0; i < Delay; i++) begin : g_dly
		always_ff @(posedge clk) ax_d[i+1] <= ax_d[i];
	end

	aar_angle u_angle (
		.clk, .arst_n, .in_valid(start), .angle(angle_deg),
		.out_valid(av), .z, .neg(ng)
	);

	aar_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk, .arst_n, .in_valid(av), .z_in(z), .neg_in(ng),
		.out_valid(cv), .cos_out(c), .sin_out(s)
	);

	aar_matrix #(.FRAC(FRAC_BITS)) u_matrix (
		.clk, .arst_n, .in_valid(cv), .c, .s, .ax(ax_d[Delay]),
		.out_valid(mv), .m, .sat(saturated)
	);

	assign done = mv;
	assign m00 = m[0]; assign m01 = m[1]; assign m02 = m[2];
	assign m10 = m[3]; assign m11 = m[4]; assign m12 = m[5];
	assign m20 = m[6]; assign m21 = m[7]; assign m22 = m[8];

endmodule

@@ rtl/aar_angle.sv @@
// ----------------------------------------------------------------------------
// aar_angle
// Angle reduction to a quarter turn and conversion to Q30 radians, 4 stages.
// ----------------------------------------------------------------------------
module aar_angle (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [19:0] angle,
	output logic               out_valid,
	output logic signed [33:0] z,
	output logic               neg
);
	import aar_pkg::*;

	// Q30 radians = mag * 31415926 * 2^20 / 450000000, split into whole and fractional parts
	localparam longint PiNum   = 64'sd31415926 * 64'sd1048576;
	localparam longint RadDen  = 64'sd450000000;
	localparam longint RadQuo  = PiNum / RadDen;
	localparam longint RadRem  = (PiNum - RadQuo * RadDen) / 128;
	localparam longint RedDen  = RadDen / 128;
	localparam longint RedBias = 64'sd225000000 / 128;
	// reciprocal of the reduced divisor scaled by 2^57, rounded up
	localparam longint Recip   = ((64'sd1 <<< 57) + RedDen - 1) / RedDen;

	localparam logic [16:0] RadQuoC  = 17'(RadQuo);
	localparam logic [20:0] RadRemC  = 21'(RadRem);
	localparam logic [20:0] RedBiasC = 21'(RedBias);
	localparam logic [35:0] RecipC   = 36'(Recip);

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [17:0] a_s1;
	logic               neg_s1, neg_s2, neg_s3, neg_s4;
	logic               sgn_s2, sgn_s3, sgn_s4;
	logic [34:0]        tr_s2;
	logic [31:0]        wq_s2, wq_s3;
	logic [53:0]        pph_s3;
	logic [52:0]        ppl_s3;
	logic [33:0]        mag_s4;

	logic signed [22:0] wide0;
	logic signed [22:0] m0;
	logic signed [22:0] a0;
	logic [15:0]        mag0;
	logic [71:0]        prod_sum;
	logic [14:0]        fq;

	// stage 1: modulo by whole turns via parallel threshold compares, then fold
	always_comb begin
		wide0 = 23'(angle);
		m0    = wide0 + 23'(6 * TurnUnits);
		for (int k = -5; k <= 6; k++)
			if (wide0 > 23'(k * TurnUnits - HalfTurn)) m0 = wide0 - 23'(k * TurnUnits);
		a0 = m0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (a0 > 23'sd23040) begin
			a_s1   <= 18'(a0 - 23'sd46080);
			neg_s1 <= 1'b1;
		end else if (a0 < -23'sd23040) begin
			a_s1   <= 18'(a0 + 23'sd46080);
			neg_s1 <= 1'b1;
		end else begin
			a_s1   <= 18'(a0);
			neg_s1 <= 1'b0;
		end
	end

	// stage 2: whole part and fractional numerator from the magnitude
	assign mag0 = a_s1[17] ? 16'(-a_s1) : 16'(a_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		tr_s2  <= 35'(mag0) * 35'(RadRemC) + 35'(RedBiasC);
		wq_s2  <= 32'(mag0) * 32'(RadQuoC);
		sgn_s2 <= a_s1[17];
		neg_s2 <= neg_s1;
	end

	// stage 3: reciprocal multiply in two halves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		pph_s3 <= 54'(tr_s2[34:17]) * 54'(RecipC);
		ppl_s3 <= 53'(tr_s2[16:0]) * 53'(RecipC);
		wq_s3  <= wq_s2;
		sgn_s3 <= sgn_s2;
		neg_s3 <= neg_s2;
	end

	// stage 4: combine halves, take quotient, add whole part
	always_comb begin
		prod_sum = {1'b0, pph_s3, 17'd0} + 72'(ppl_s3);
		fq       = prod_sum[71:57];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else         v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		mag_s4 <= 34'(wq_s3) + 34'(fq);
		sgn_s4 <= sgn_s3;
		neg_s4 <= neg_s3;
	end

	assign out_valid = v_s4;
	assign z   = sgn_s4 ? -$signed(mag_s4) : $signed(mag_s4);
	assign neg = neg_s4;

endmodule

@@ rtl/aar_cordic.sv @@
// ----------------------------------------------------------------------------
// aar_cordic
// Unrolled rotation-mode CORDIC, one register stage per rotation.
// ----------------------------------------------------------------------------
module aar_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [33:0] z_in,
	input  logic               neg_in,
	output logic               out_valid,
	output logic signed [33:0] cos_out,
	output logic signed [33:0] sin_out
);
	import aar_pkg::*;

	localparam int N = (STEPS > 32) ? 32 : STEPS;

	logic               v_q   [N+1];
	logic               neg_q [N+1];
	logic signed [33:0] x_q   [N+1];
	logic signed [33:0] y_q   [N+1];
	logic signed [33:0] z_q   [N+1];

	assign v_q[0]   = in_valid;
	assign neg_q[0] = neg_in;
	assign x_q[0]   = GainQ30;
	assign y_q[0]   = '0;
	assign z_q[0]   = z_in;

	// one micro-rotation per stage
	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[i+1] <= 1'b0;
			else         v_q[i+1] <= v_q[i];
		end
		always_ff @(posedge clk) begin
			neg_q[i+1] <= neg_q[i];
			if (!z_q[i][33]) begin
				x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] - atan_q30(i);
			end else begin
				x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
				y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
				z_q[i+1] <= z_q[i] + atan_q30(i);
			end
		end
	end

	assign out_valid = v_q[N];
	assign cos_out   = neg_q[N] ? -x_q[N] : x_q[N];
	assign sin_out   = neg_q[N] ? -y_q[N] : y_q[N];

endmodule

@@ rtl/aar_matrix.sv @@
// ----------------------------------------------------------------------------
// aar_matrix
// Rodrigues matrix entries from cos, sin and the axis, with saturation.
// ----------------------------------------------------------------------------
module aar_matrix #(
	parameter int FRAC = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic signed [33:0] c,
	input  logic signed [33:0] s,
	input  logic signed [15:0] ax [3],
	output logic               out_valid,
	output logic signed [15:0] m  [9],
	output logic               sat
);
	import aar_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [33:0] omc_s1, c_s1, s_s1;
	logic signed [31:0] aa_s1 [9];
	logic signed [15:0] ax_s1 [3];
	logic signed [65:0] p_s2  [9];
	logic signed [65:0] d_s2  [9];
	logic signed [65:0] sum_s3[9];
	logic signed [15:0] m_s4  [9];
	logic               sat_s4;

	// stage 1: axis products, one minus cos
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		omc_s1 <= OneQ30 - c;
		c_s1   <= c;
		s_s1   <= s;
		for (int k = 0; k < 9; k++) aa_s1[k] <= 32'(ax[k/3] * ax[k%3]);
		for (int k = 0; k < 3; k++) ax_s1[k] <= ax[k];
	end

	// stage 2: (1-cos)*aa and cos or sin terms
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			p_s2[k] <= (66'(omc_s1) * 66'(aa_s1[k]) + (66'sd1 <<< (FRAC - 1))) >>> FRAC;
		end
		d_s2[0] <= 66'(c_s1) <<< FRAC;
		d_s2[4] <= 66'(c_s1) <<< FRAC;
		d_s2[8] <= 66'(c_s1) <<< FRAC;
		d_s2[1] <= -(66'(s_s1) * 66'(ax_s1[2]));
		d_s2[2] <=   66'(s_s1) * 66'(ax_s1[1]);
		d_s2[3] <=   66'(s_s1) * 66'(ax_s1[2]);
		d_s2[5] <= -(66'(s_s1) * 66'(ax_s1[0]));
		d_s2[6] <= -(66'(s_s1) * 66'(ax_s1[1]));
		d_s2[7] <=   66'(s_s1) * 66'(ax_s1[0]);
	end

	// stage 3: sum and round by 30 bits
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++)
			sum_s3[k] <= (p_s2[k] + d_s2[k] + (66'sd1 <<< 29)) >>> 30;
	end

	// stage 4: clamp
	always_ff @(posedge clk) begin
		logic any;
		any = 1'b0;
		for (int k = 0; k < 9; k++) begin
			if (sum_s3[k] > 66'sd32767) begin
				m_s4[k] <= 16'sh7fff; any = 1'b1;
			end else if (sum_s3[k] < -66'sd32768) begin
				m_s4[k] <= 16'sh8000; any = 1'b1;
			end else begin
				m_s4[k] <= sum_s3[k][15:0];
			end
		end
		sat_s4 <= any;
	end

	assign out_valid = v_s4;
	assign m   = m_s4;
	assign sat = sat_s4;

endmodule

@@ tb/rotation_checker.sv @@
// ----------------------------------------------------------------------------
// rotation_checker
// Watches the request and result channels of the axis-angle rotation block,
// predicts each matrix from the axis and angle, and compares in order.
// ----------------------------------------------------------------------------
module rotation_checker #(
	parameter int CORDIC_STEPS = 16,
	parameter int FRAC_BITS    = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] axis_z,
	input  logic signed [19:0] angle_deg,
	input  logic               done,
	input  logic signed [15:0] m00, m01, m02,
	input  logic signed [15:0] m10, m11, m12,
	input  logic signed [15:0] m20, m21, m22,
	input  logic               saturated,
	output int                 fail_count,
	output int                 pending,
	output int                 matrices_seen,
	output int                 clamped_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [8:0][15:0] entry;
		logic                    clamped;
	} matrix_t;

	matrix_t expected_matrices[$];

	// arithmetic shift right with floor
	function automatic longint shr_floor(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint round_half_up(longint v, int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	function automatic longint atan_entry(int i);
		longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10)
			return t[i];
		return (i < 31) ? (longint'(1) <<< (30 - i)) : 0;
	endfunction

	// rodrigues matrix of one request
	function automatic matrix_t rotation_of(logic signed [15:0] ax, logic signed [15:0] ay,
			logic signed [15:0] az, logic signed [19:0] ang);
		longint a3[3];
		longint a, mag, z, x, y, dx, dy, c, s, omc, r;
		longint p[3][3];
		logic flip;
		int steps;
		matrix_t m;
		a3[0] = ax; a3[1] = ay; a3[2] = az;
		flip = 0;
		steps = CORDIC_STEPS > 32 ? 32 : CORDIC_STEPS;
		a = longint'(ang) % aar_pkg::TurnUnits;
		if (a < 0) a += aar_pkg::TurnUnits;
		if (a > aar_pkg::HalfTurn) a -= aar_pkg::TurnUnits;
		if (a > aar_pkg::QuarterTurn) begin
			a -= aar_pkg::HalfTurn; flip = 1;
		end else if (a < -aar_pkg::QuarterTurn) begin
			a += aar_pkg::HalfTurn; flip = 1;
		end
		mag = a < 0 ? -a : a;
		z = (mag * 31415926 * 1048576 + 225000000) / 450000000;
		if (a < 0) z = -z;
		x = 652032874;
		y = 0;
		// cordic rotation
		for (int i = 0; i < steps; i++) begin
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_entry(i);
			end else begin
				x += dx; y -= dy; z += atan_entry(i);
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
		omc = 64'sd1073741824 - c;
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				p[i][k] = round_half_up(omc * (a3[i] * a3[k]), FRAC_BITS);
		for (int i = 0; i < 3; i++)
			p[i][i] += c * (longint'(1) <<< FRAC_BITS);
		p[0][1] -= s * a3[2];
		p[0][2] += s * a3[1];
		p[1][0] += s * a3[2];
		p[1][2] -= s * a3[0];
		p[2][0] -= s * a3[1];
		p[2][1] += s * a3[0];
		m.clamped = 0;
		// round and clamp each entry
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++) begin
				r = round_half_up(p[i][k], 30);
				if (r > 32767) begin
					r = 32767; m.clamped = 1;
				end
				if (r < -32768) begin
					r = -32768; m.clamped = 1;
				end
				m.entry[i * 3 + k] = r[15:0];
			end
		return m;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	// record requests and compare results
	always @(posedge clk) begin
		matrix_t want;
		logic signed [8:0][15:0] got;
		got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
		if (arst_n && start && !busy)
			expected_matrices.push_back(rotation_of(axis_x, axis_y, axis_z, angle_deg));
		if (arst_n && done) begin
			matrices_seen++;
			if (saturated) clamped_seen++;
			if (expected_matrices.size() == 0) begin
				$display("%0t result with no request outstanding", $realtime);
				fail_count++;
			end else begin
				want = expected_matrices.pop_front();
				for (int i = 0; i < 9; i++)
					if (got[i] !== want.entry[i])
						report_mismatch($sformatf("m%0d%0d", i / 3, i % 3),
							got[i], want.entry[i]);
				if (saturated !== want.clamped)
					report_mismatch("saturated", saturated, want.clamped);
			end
		end
		pending = expected_matrices.size();
	end

	initial begin
		fail_count = 0;
		pending = 0;
		matrices_seen = 0;
		clamped_seen = 0;
	end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives axis-angle requests into the rotation block: directed corners first,
// then random axes and angles under several idling phases; the checker
// predicts and compares every matrix.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int Latency = 4 + 16 + 4;
	localparam int CycleLimit = 200000;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [15:0] axis_x, axis_y, axis_z;
	logic signed [19:0] angle_deg;
	logic               done;
	logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic               saturated;
	int                 fail_count, pending, matrices_seen, clamped_seen;
	int                 cycle_count;
	int                 idle_pct;

	axis_angle_rotation_matrix dut (.*);

	rotation_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CycleLimit) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// one request, with random idle cycles before it
	task automatic send_request(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic signed [19:0] ang);
		while ($urandom_range(99) < idle_pct) begin
			start <= 0;
			@(posedge clk);
		end
		start <= 1;
		axis_x <= x;
		axis_y <= y;
		axis_z <= z;
		angle_deg <= ang;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	function automatic logic signed [15:0] random_axis(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(32768)) - 16384);
			default: return 16'($signed($urandom_range(2000)) - 1000);
		endcase
	endfunction

	initial begin
		int mode;
		logic signed [19:0] ang;
		start = 0;
		axis_x = 0;
		axis_y = 0;
		axis_z = 0;
		angle_deg = 0;
		idle_pct = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, quadrant edges, zero and large axes
		send_request(16'sd16384, 0, 0, 0);
		send_request(0, 16'sd16384, 0, 20'sd23040);
		send_request(0, 0, 16'sd16384, -20'sd23040);
		send_request(16'sd16384, 0, 0, 20'sd23041);
		send_request(16'sd16384, 0, 0, -20'sd23041);
		send_request(0, 0, 16'sd16384, 20'sd46080);
		send_request(0, 0, 16'sd16384, -20'sd46080);
		send_request(16'sd9459, 16'sd9459, 16'sd9459, 20'sd92160);
		send_request(0, 0, 0, 20'sd11520);
		send_request(16'sh7fff, 16'sh7fff, 16'sh7fff, 20'sh7ffff);
		send_request(-16'sd32768, -16'sd32768, -16'sd32768, -20'sd524288);
		send_request(16'sh7fff, -16'sd32768, 16'sh7fff, 20'sd46080);
		send_request(-16'sd32768, 16'sh7fff, 0, 20'sd69120);
		send_request(16'sd16384, 16'sd16384, 16'sd16384, 20'sd23040);
		send_request(-16'sd1, -16'sd1, -16'sd1, -20'sd1);
		send_request(16'sd1, 16'sd1, 16'sd1, 20'sd1);
		send_request(16'sd11585, -16'sd11585, 0, -20'sd69120);
		send_request(0, 16'sd16384, 0, 20'sd92159);

		// random phases: none, heavy sender idle, light sender idle, none again
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 62 : (ph == 2) ? 35 : 0;
			for (int n = 0; n < 420; n++) begin
				mode = $urandom_range(2);
				case ($urandom_range(3))
					0: ang = 20'($urandom);
					1: ang = 20'($signed($urandom_range(92160)) - 46080);
					2: ang = 20'(23040 * ($signed($urandom_range(8)) - 4)
						+ $signed($urandom_range(4)) - 2);
					default: ang = 20'($signed($urandom_range(2000)) - 1000);
				endcase
				send_request(random_axis(mode), random_axis(mode), random_axis(mode), ang);
			end
		end
		start <= 0;

		// drain
		while (pending != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);

		$display("checked %0d rotation matrices, %0d with clamped entries",
			matrices_seen, clamped_seen);
		if (fail_count == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
